[design/kvt_pkg.sv]
package kvt_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_OVERWRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef logic signed [WordW-1:0] word_t;

endpackage

[design/kvt_if.sv]
interface kvt_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink (input valid, input status, input read_value, output ready);
endinterface

[design/key_value_table.sv]
// key_value_table: associative table of unique 32-bit keys, one 32-bit value each.
// req_i (valid/ready) takes one beat per operation: opcode, key, value.
// rsp_o (valid/ready) returns one beat per operation: status and read_value.
// keys live in one ram with a valid bit beside each key, values in a second ram;
// both are read together at one address per cycle and written back at the end.
// the scan reads slot by slot and stops at a key match, so a miss, and any insert
// of a new key, reads every slot before rsp_o.valid rises. one operation is in the
// scan at a time: req_i.ready stays low until its result is registered.
// reset: the table starts empty. after rst_ni is released the key ram is swept
// slot by slot to clear its valid bits; req_i.ready stays low meanwhile.
// stall: a finished result waits in the output register; the next request is
// still taken and scanned, and its write-back and result wait until the
// receiver takes the pending beat.
module key_value_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  kvt_req_if.sink   req_i,
  kvt_rsp_if.source rsp_o
);

  import kvt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LastIdx = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] CntEnd = CW'(ENTRIES);

  state_e state_q, state_d;

  op_e          op_q, op_d;
  word_t        key_q, key_d;
  word_t        val_q, val_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic         chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;
  logic         found_q, found_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  word_t        hit_val_q, hit_val_d;
  logic         free_ok_q, free_ok_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic         out_vld_q, out_vld_d;
  status_e      out_status_q, out_status_d;
  word_t        out_rv_q, out_rv_d;

  // ram ports
  logic          key_we, val_we, rd_en;
  logic [AW-1:0] key_waddr, val_waddr, rd_addr;
  logic [WordW:0] key_wdata, key_rd;
  word_t         val_rd;

  logic    req_fire, fire, hit, free_seen, scan_last, ins_ok;
  status_e status_c;

  assign req_fire  = req_i.valid && req_i.ready;
  assign fire      = (state_q == S_EXEC) && (!out_vld_q || rsp_o.ready);
  assign hit       = chk_vld_q && key_rd[WordW] && (key_rd[WordW-1:0] == key_q);
  assign free_seen = chk_vld_q && !key_rd[WordW];
  assign scan_last = chk_vld_q && (chk_idx_q == LastIdx);
  assign ins_ok    = (op_q == OP_INSERT) && !found_q && free_ok_q;

  always_comb begin
    case (op_q)
      OP_INSERT: begin
        if (found_q) begin
          status_c = ST_DUP;
        end else if (!free_ok_q) begin
          status_c = ST_FULL;
        end else begin
          status_c = ST_OK;
        end
      end
      default: status_c = found_q ? ST_OK : ST_NOT_FOUND;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q[AW-1:0] == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // state outputs: handshake and ram control
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[AW-1:0];
    key_we      = 1'b0;
    key_waddr   = cnt_q[AW-1:0];
    key_wdata   = '0;
    val_we      = 1'b0;
    val_waddr   = (op_q == OP_INSERT) ? free_idx_q : hit_idx_q;
    case (state_q)
      S_CLEAR: begin
        key_we = 1'b1;
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
      end
      S_SCAN: begin
        rd_en = (cnt_q < CntEnd);
      end
      S_EXEC: begin
        key_waddr = (op_q == OP_INSERT) ? free_idx_q : hit_idx_q;
        key_wdata = {ins_ok, key_q};
        key_we    = fire && (ins_ok || ((op_q == OP_REMOVE) && found_q));
        val_we    = fire && (ins_ok || ((op_q == OP_OVERWRITE) && found_q));
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_val_d    = hit_val_q;
    free_ok_d    = free_ok_q;
    free_idx_d   = free_idx_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_rv_d     = out_rv_q;
    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (req_fire) begin
          op_d      = op_e'(req_i.opcode);
          key_d     = req_i.key;
          val_d     = req_i.value;
          cnt_d     = '0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[AW-1:0];
        end
        if (hit) begin
          found_d   = 1'b1;
          hit_idx_d = chk_idx_q;
          hit_val_d = val_rd;
          chk_vld_d = 1'b0;
        end
        // lowest free slot wins
        if (free_seen && !free_ok_q) begin
          free_ok_d  = 1'b1;
          free_idx_d = chk_idx_q;
        end
      end
      S_EXEC: begin
        if (fire) begin
          out_vld_d    = 1'b1;
          out_status_d = status_c;
          out_rv_d     = ((op_q == OP_LOOKUP) && found_q) ? hit_val_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      free_ok_q <= free_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    chk_idx_q    <= chk_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_val_q    <= hit_val_d;
    free_idx_q   <= free_idx_d;
    out_status_q <= out_status_d;
    out_rv_q     <= out_rv_d;
  end

  kvt_ram #(
    .WIDTH(WordW + 1),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk_i    (clk_i),
    .wr_en_i  (key_we),
    .wr_addr_i(key_waddr),
    .wr_data_i(key_wdata),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(key_rd)
  );

  kvt_ram #(
    .WIDTH(WordW),
    .DEPTH(ENTRIES)
  ) u_val_ram (
    .clk_i    (clk_i),
    .wr_en_i  (val_we),
    .wr_addr_i(val_waddr),
    .wr_data_i(val_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(val_rd)
  );

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_rv_q;

endmodule

[design/kvt_ram.sv]
module kvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                          wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                          rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/kvt_checker.sv]
module kvt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic signed [31:0] rsp_read_value_i
);

  import kvt_pkg::*;

  logic       req_beat, rsp_beat;
  logic [1:0] pending_q, pending_d;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  // operations taken but not yet answered
  always_comb begin
    pending_d = pending_q;
    case ({req_beat, rsp_beat})
      2'b10:   pending_d = pending_q + 2'd1;
      2'b01:   pending_d = pending_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_read_value_i))
    else $error("response beat changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |=> !req_ready_i)
    else $error("request taken while previous one is still scanned");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pending_q != 2'd0) && (pending_q != 2'd3))
    else $error("response without a matching request");

  a_rv_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> rsp_read_value_i == '0)
    else $error("nonzero read value on failed operation");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_read_value_i(rsp_o.read_value)
);

[tb/sv/key_value_table_test.sv]
module key_value_table_test;
  import kvt_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned DRAIN_CYCLES = 2 * (ENTRIES + 3);
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_PRINTS   = 50;

  localparam word_t KEY_MIN = word_t'(32'h8000_0000);
  localparam word_t KEY_MAX = word_t'(32'h7fff_ffff);
  localparam word_t ALL_ONE = word_t'(32'hffff_ffff);

  typedef struct packed {
    status_e status;
    word_t   read_value;
  } result_t;

  logic clk;
  logic rst_n;

  kvt_req_if req_if ();
  kvt_rsp_if rsp_if ();

  key_value_table #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the table, updated on every accepted request beat
  word_t   tbl_key  [ENTRIES];
  word_t   tbl_val  [ENTRIES];
  bit      tbl_used [ENTRIES];
  result_t pending_results[$];

  word_t key_pool [POOL_SIZE];
  int    send_idle_pct;
  int    recv_stall_pct;
  int    error_count;
  int    cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL key_value_table");
      $finish;
    end
  end

  function automatic result_t apply_op(op_e op, word_t key, word_t value);
    int      hit;
    int      free_idx;
    result_t res;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_used[i] && tbl_key[i] == key) hit = i;
      if (free_idx < 0 && !tbl_used[i]) free_idx = i;
    end
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      OP_INSERT: begin
        // a duplicate wins over a full table
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (free_idx < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_key[free_idx]  = key;
          tbl_val[free_idx]  = value;
          tbl_used[free_idx] = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else tbl_used[hit] = 1'b0;
      end
      OP_LOOKUP: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.read_value = tbl_val[hit];
      end
      default: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else tbl_val[hit] = value;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin : predict_results
    result_t exp_res;
    if (rst_n && req_if.valid && req_if.ready) begin
      exp_res = apply_op(op_e'(req_if.opcode), req_if.key, req_if.value);
      pending_results = {pending_results, exp_res};
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
        end
        if (rsp_if.read_value !== want.read_value) begin
          report_mismatch($sformatf("read_value %h, expected %h",
                                    rsp_if.read_value, want.read_value));
        end
      end
    end
  end

  // called and returns at a falling edge; valid is only lowered for an idle gap
  task automatic send_item(input op_e op, input word_t key, input word_t value);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key    <= key;
    req_if.value  <= value;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic refresh_key_pool();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = ALL_ONE;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = word_t'($urandom);
  endtask

  function automatic word_t pick_key();
    int sel;
    int live[$];
    sel = $urandom_range(99);
    if (sel < 65) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (sel < 85) begin
      for (int i = 0; i < ENTRIES; i++) if (tbl_used[i]) live = {live, i};
      if (live.size() > 0) return tbl_key[live[$urandom_range(live.size() - 1)]];
    end
    return word_t'($urandom);
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(19))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      3:       return ALL_ONE;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic op_e pick_op();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return OP_INSERT;
    if (sel < 55) return OP_REMOVE;
    if (sel < 80) return OP_LOOKUP;
    return OP_OVERWRITE;
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_REMOVE, word_t'(5), '0);
    send_item(OP_OVERWRITE, word_t'(5), word_t'(9));
    send_item(OP_INSERT, KEY_MIN, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN, '0);
    send_item(OP_LOOKUP, KEY_MIN, '0);
    send_item(OP_OVERWRITE, KEY_MIN, KEY_MIN);
    send_item(OP_LOOKUP, KEY_MIN, ALL_ONE);
    send_item(OP_INSERT, KEY_MAX, '0);
    send_item(OP_INSERT, '0, ALL_ONE);
    send_item(OP_INSERT, ALL_ONE, KEY_MIN);
    send_item(OP_REMOVE, KEY_MAX, '0);
    send_item(OP_LOOKUP, KEY_MAX, '0);
    // three entries held, thirteen more fill the table
    for (int i = 1; i <= 13; i++) begin
      send_item(OP_INSERT, word_t'(i * 32'h1111_1111), word_t'(~(i * 32'h1111_1111)));
    end
    send_item(OP_INSERT, KEY_MAX, word_t'(1));
    send_item(OP_INSERT, '0, word_t'(1));
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    refresh_key_pool();
    for (int n = 0; n < count; n++) send_item(pick_op(), pick_key(), pick_value());
  endtask

  // empty the table, fill past capacity with fresh keys, read them and rewrite some, then empty it again
  task automatic test_fill_flush(input int send_pct, input int recv_pct);
    word_t fresh[$];
    int    idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < ENTRIES; i++) if (tbl_used[i]) send_item(OP_REMOVE, tbl_key[i], '0);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      fresh = {fresh, word_t'($urandom)};
      send_item(OP_INSERT, fresh[i], pick_value());
    end
    for (int i = 0; i < fresh.size(); i++) begin
      if ($urandom_range(1)) send_item(OP_OVERWRITE, fresh[i], pick_value());
      send_item(OP_LOOKUP, fresh[i], '0);
    end
    while (fresh.size() > 0) begin
      idx = $urandom_range(fresh.size() - 1);
      send_item(OP_REMOVE, fresh[idx], '0);
      fresh.delete(idx);
    end
    send_item(OP_LOOKUP, word_t'($urandom), '0);
  endtask

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.opcode  = OP_INSERT;
    req_if.key     = '0;
    req_if.value   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    cycle_count    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_key[i]  = '0;
      tbl_val[i]  = '0;
      tbl_used[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(350, 0, 0);
    test_fill_flush(0, 0);
    test_random(350, 61, 0);
    wait_results();
    test_random(350, 0, 61);
    test_fill_flush(29, 29);
    test_random(350, 29, 29);

    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS key_value_table");
    end else begin
      $display("FAIL key_value_table");
    end
    $finish;
  end

endmodule

[files.f]
design/kvt_pkg.sv
design/kvt_if.sv
design/kvt_ram.sv
design/key_value_table.sv
design/kvt_checker.sv
tb/sv/key_value_table_test.sv
